### hw/rtl/elhc_pkg.sv
// Shared types, constants and reset values of the link header classifier.
package elhc_pkg;

    localparam int unsigned HDR_MAX     = 26;
    localparam int unsigned HDR_FIRST   = 12;
    localparam int unsigned VIEW_BYTES  = HDR_MAX - HDR_FIRST;
    localparam int unsigned ETH_LEN     = 14;
    localparam int unsigned TAG_LEN     = 4;
    localparam int unsigned LLC_LEN     = 3;
    localparam int unsigned SNAP_LEN    = 5;
    localparam int unsigned OFFSET_MAX  = 31;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0]  SAP_SNAP     = 8'haa;
    localparam logic [7:0]  CTRL_UI      = 8'h03;

    localparam logic [15:0] LENGTH_LIMIT_RST = 16'd1500;
    localparam logic [15:0] VLAN_TYPE_RST    = 16'h8100;
    localparam logic [23:0] ORG_ETHER_RST    = 24'h000000;
    localparam logic [23:0] ORG_APPLE_RST    = 24'h080007;
    localparam logic [23:0] ORG_CISCO_RST    = 24'h00000c;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LENGTH_LIMIT = 3'd0,
        REG_VLAN_TYPE    = 3'd1,
        REG_ORG_ETHER    = 3'd2,
        REG_ORG_APPLE    = 3'd3,
        REG_ORG_CISCO    = 3'd4
    } reg_index_t;

    typedef enum logic [2:0] {
        KIND_TRUNC      = 3'd0,
        KIND_ETHERNET   = 3'd1,
        KIND_LLC        = 3'd2,
        KIND_SNAP_ETHER = 3'd3,
        KIND_SNAP_APPLE = 3'd4,
        KIND_SNAP_CISCO = 3'd5,
        KIND_SNAP_OTHER = 3'd6
    } kind_t;

    typedef struct packed {
        logic [15:0] length_limit;
        logic [15:0] vlan_type;
        logic [23:0] org_ether;
        logic [23:0] org_apple;
        logic [23:0] org_cisco;
    } cfg_t;

    // Frame length and header bytes 12 to 25 of one finished frame
    typedef struct packed {
        logic [5:0]                 len;
        logic [VIEW_BYTES-1:0][7:0] view;
    } desc_t;

    typedef struct packed {
        kind_t       kind;
        logic        vlan_tagged;
        logic [15:0] next_protocol;
        logic [4:0]  header_length;
        logic [7:0]  dest_sap;
        logic [7:0]  source_sap;
    } result_t;

endpackage

### hw/rtl/ethernet_link_header_classifier_unit.sv
// Top level of the Ethernet link header classifier.
//
//  channel   handshake          payload
//  input     push / full        frame_byte, last_byte
//  result    empty / pop        frame_kind, vlan_tagged, next_protocol,
//                               header_length, dest_sap, source_sap
//  config    cfg_write          cfg_index, cfg_data
//
// One byte is taken every cycle while full is low; the descriptor of a frame whose
// last-byte mark was taken is registered in the descriptor queue, then in the output register.
// full rises only when the descriptor queue holds QUEUE_DEPTH finished frames
// and the output register is held by a stalled reader.
// Reset clears the byte counter, empties the queue and output register and loads the
// register defaults; no clearing pass is needed.
module ethernet_link_header_classifier_unit import elhc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = elhc_pkg::QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             frame_byte,
    input  logic                   last_byte,
    output logic                   empty,
    input  logic                   pop,
    output logic [2:0]             frame_kind,
    output logic                   vlan_tagged,
    output logic [15:0]            next_protocol,
    output logic [4:0]             header_length,
    output logic [7:0]             dest_sap,
    output logic [7:0]             source_sap,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    accept;
    logic    desc_push;
    desc_t   desc_in;
    desc_t   desc_out;
    logic    desc_pop;
    logic    desc_empty;
    logic    desc_full;
    result_t res;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_LENGTH_LIMIT: cfg_next.length_limit = cfg_data[15:0];
                REG_VLAN_TYPE:    cfg_next.vlan_type    = cfg_data[15:0];
                REG_ORG_ETHER:    cfg_next.org_ether    = cfg_data;
                REG_ORG_APPLE:    cfg_next.org_apple    = cfg_data;
                REG_ORG_CISCO:    cfg_next.org_cisco    = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.length_limit <= LENGTH_LIMIT_RST;
            cfg_reg.vlan_type    <= VLAN_TYPE_RST;
            cfg_reg.org_ether    <= ORG_ETHER_RST;
            cfg_reg.org_apple    <= ORG_APPLE_RST;
            cfg_reg.org_cisco    <= ORG_CISCO_RST;
        end
        else
            cfg_reg <= cfg_next;
    end

    assign full   = desc_full;
    assign accept = push && !desc_full;

    elhc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .desc_push  (desc_push),
        .desc       (desc_in)
    );

    elhc_queue #(
        .WIDTH ($bits(desc_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (desc_push),
        .wr_data (desc_in),
        .rd_en   (desc_pop),
        .rd_data (desc_out),
        .empty   (desc_empty),
        .full    (desc_full)
    );

    elhc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .desc       (desc_out),
        .desc_empty (desc_empty),
        .desc_pop   (desc_pop),
        .pop        (pop),
        .empty      (empty),
        .res        (res)
    );

    assign frame_kind    = res.kind;
    assign vlan_tagged   = res.vlan_tagged;
    assign next_protocol = res.next_protocol;
    assign header_length = res.header_length;
    assign dest_sap      = res.dest_sap;
    assign source_sap    = res.source_sap;

endmodule

### hw/rtl/elhc_front.sv
// Front end: byte counter and header capture, emits one descriptor per frame.
module elhc_front import elhc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] frame_byte,
    input  logic       last_byte,
    output logic       desc_push,
    output desc_t      desc
);

    logic [4:0]                 offset_reg;
    logic [4:0]                 offset_next;
    logic [VIEW_BYTES-1:0][7:0] hdr_reg;

    always_comb
    begin
        offset_next = offset_reg;
        if (accept)
        begin
            if (last_byte)
                offset_next = '0;
            else if (offset_reg != 5'(OFFSET_MAX))
                offset_next = offset_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= '0;
        else
            offset_reg <= offset_next;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < VIEW_BYTES; k++)
        begin
            if (accept && offset_reg == 5'(HDR_FIRST + k))
                hdr_reg[k] <= frame_byte;
        end
    end

    // Merge the final byte into the captured header
    always_comb
    begin
        desc.len = {1'b0, offset_reg} + 6'd1;
        for (int k = 0; k < VIEW_BYTES; k++)
        begin
            if (offset_reg == 5'(HDR_FIRST + k))
                desc.view[k] = frame_byte;
            else
                desc.view[k] = hdr_reg[k];
        end
    end

    assign desc_push = accept && last_byte;

    a_offset_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> offset_reg == '0)
        else $error("byte offset did not restart after the last byte");

endmodule

### hw/rtl/elhc_queue.sv
// Small register queue carrying frame descriptors from front to back.
module elhc_queue import elhc_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty,
    output logic             full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

endmodule

### hw/rtl/elhc_back.sv
// Back end: decodes a frame descriptor and holds the result for the reader.
module elhc_back import elhc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  desc_t   desc,
    input  logic    desc_empty,
    output logic    desc_pop,
    input  logic    pop,
    output logic    empty,
    output result_t res
);

    result_t     res_reg;
    result_t     res_next;
    logic        valid_reg;
    logic        valid_next;

    logic [15:0] t0;
    logic [15:0] t1;
    logic        eth_ok;
    logic        has_tag;
    logic        tag_ok;
    logic        llc;
    logic [5:0]  base;
    logic [7:0]  d;
    logic [7:0]  s;
    logic [7:0]  c;
    logic [23:0] org;
    logic [15:0] snap_proto;

    assign t0      = {desc.view[0], desc.view[1]};
    assign t1      = {desc.view[4], desc.view[5]};
    assign eth_ok  = desc.len >= 6'(ETH_LEN);
    assign has_tag = eth_ok && (t0 > cfg.length_limit) && (t0 == cfg.vlan_type);
    assign tag_ok  = has_tag && desc.len >= 6'(ETH_LEN + TAG_LEN);
    assign llc     = (eth_ok && t0 <= cfg.length_limit) || (tag_ok && t1 <= cfg.length_limit);
    assign base    = has_tag ? 6'(ETH_LEN + TAG_LEN) : 6'(ETH_LEN);

    always_comb
    begin
        if (has_tag)
        begin
            d          = desc.view[6];
            s          = desc.view[7];
            c          = desc.view[8];
            org        = {desc.view[9], desc.view[10], desc.view[11]};
            snap_proto = {desc.view[12], desc.view[13]};
        end
        else
        begin
            d          = desc.view[2];
            s          = desc.view[3];
            c          = desc.view[4];
            org        = {desc.view[5], desc.view[6], desc.view[7]};
            snap_proto = {desc.view[8], desc.view[9]};
        end
    end

    always_comb
    begin
        result_t r;
        r               = '0;
        r.kind          = KIND_TRUNC;
        r.vlan_tagged   = has_tag;
        if (eth_ok && !llc)
        begin
            if (!has_tag)
            begin
                r.kind          = KIND_ETHERNET;
                r.next_protocol = t0;
                r.header_length = 5'(ETH_LEN);
            end
            else if (tag_ok)
            begin
                r.kind          = KIND_ETHERNET;
                r.next_protocol = t1;
                r.header_length = 5'(ETH_LEN + TAG_LEN);
            end
        end
        if (llc && desc.len >= base + 6'(LLC_LEN))
        begin
            if (d == SAP_SNAP && s == SAP_SNAP && c == CTRL_UI)
            begin
                if (desc.len >= base + 6'(LLC_LEN + SNAP_LEN))
                begin
                    if (org == cfg.org_ether)
                        r.kind = KIND_SNAP_ETHER;
                    else if (org == cfg.org_apple)
                        r.kind = KIND_SNAP_APPLE;
                    else if (org == cfg.org_cisco)
                        r.kind = KIND_SNAP_CISCO;
                    else
                        r.kind = KIND_SNAP_OTHER;
                    r.next_protocol = snap_proto;
                    r.header_length = 5'(base + 6'(LLC_LEN + SNAP_LEN));
                    r.dest_sap      = d;
                    r.source_sap    = s;
                end
            end
            else
            begin
                r.kind          = KIND_LLC;
                r.header_length = 5'(base + 6'(LLC_LEN));
                r.dest_sap      = d;
                r.source_sap    = s;
            end
        end
        res_next = r;
    end

    // Refill the output register when it is free or being drained
    assign desc_pop = !desc_empty && (!valid_reg || pop);

    always_comb
    begin
        valid_next = valid_reg;
        if (desc_pop)
            valid_next = 1'b1;
        else if (pop)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (desc_pop)
            res_reg <= res_next;
    end

    assign empty = !valid_reg;
    assign res   = res_reg;

    a_trunc_clean: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && res_reg.kind == KIND_TRUNC |->
            res_reg.header_length == '0 && res_reg.next_protocol == '0)
        else $error("truncated frame carries header fields");

    a_eth_no_sap: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && res_reg.kind == KIND_ETHERNET |->
            res_reg.dest_sap == '0 && res_reg.source_sap == '0)
        else $error("Ethernet II frame reports LLC SAPs");

endmodule

### dv/tb.sv
// Self-checking testbench for the Ethernet link header classifier.
`timescale 1ns / 100ps

module tb;
    import elhc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;

    typedef enum {
        SHAPE_ETH,
        SHAPE_VLAN,
        SHAPE_LLC,
        SHAPE_SNAP,
        SHAPE_VLAN_LLC,
        SHAPE_VLAN_SNAP,
        SHAPE_NOISE
    } frame_shape_t;

    class frame_header_checker;
        logic [15:0] limit;
        logic [15:0] vlan;
        logic [23:0] org_ether;
        logic [23:0] org_apple;
        logic [23:0] org_cisco;
        logic [4:0]  offset;
        logic [7:0]  hdr [HDR_MAX];
        result_t     headers_due[$];
        int          errors;

        function new();
            limit     = LENGTH_LIMIT_RST;
            vlan      = VLAN_TYPE_RST;
            org_ether = ORG_ETHER_RST;
            org_apple = ORG_APPLE_RST;
            org_cisco = ORG_CISCO_RST;
            offset    = '0;
            errors    = 0;
            foreach (hdr[i])
                hdr[i] = '0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_LENGTH_LIMIT: limit     = val[15:0];
                REG_VLAN_TYPE:    vlan      = val[15:0];
                REG_ORG_ETHER:    org_ether = val;
                REG_ORG_APPLE:    org_apple = val;
                REG_ORG_CISCO:    org_cisco = val;
                default: ;
            endcase
        endfunction

        function logic [15:0] word_at(int unsigned i);
            return {hdr[i], hdr[i + 1]};
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            int unsigned len;
            int unsigned base;
            int unsigned o;
            logic [15:0] t;
            logic [23:0] org;
            logic [7:0]  d;
            logic [7:0]  s;
            logic [7:0]  c;
            bit          llc;
            result_t     r;
            if (offset < HDR_MAX)
                hdr[offset] = b;
            if (!last) begin
                if (offset < OFFSET_MAX)
                    offset++;
                return;
            end
            len    = int'(offset) + 1;
            offset = '0;
            base   = ETH_LEN;
            llc    = 1'b0;
            r      = '0;
            r.kind = KIND_TRUNC;
            if (len >= ETH_LEN) begin
                t = word_at(12);
                if (t <= limit)
                    llc = 1'b1;
                else if (t == vlan) begin
                    r.vlan_tagged = 1'b1;
                    base          = ETH_LEN + TAG_LEN;
                    if (len >= base) begin
                        t = word_at(16);
                        if (t <= limit)
                            llc = 1'b1;
                        else begin
                            r.kind          = KIND_ETHERNET;
                            r.next_protocol = t;
                            r.header_length = 5'(base);
                        end
                    end
                end else begin
                    r.kind          = KIND_ETHERNET;
                    r.next_protocol = t;
                    r.header_length = 5'(ETH_LEN);
                end
            end
            if (llc && len >= base + LLC_LEN) begin
                d = hdr[base];
                s = hdr[base + 1];
                c = hdr[base + 2];
                if (d == SAP_SNAP && s == SAP_SNAP && c == CTRL_UI) begin
                    if (len >= base + LLC_LEN + SNAP_LEN) begin
                        o   = base + LLC_LEN;
                        org = {hdr[o], hdr[o + 1], hdr[o + 2]};
                        if (org == org_ether)
                            r.kind = KIND_SNAP_ETHER;
                        else if (org == org_apple)
                            r.kind = KIND_SNAP_APPLE;
                        else if (org == org_cisco)
                            r.kind = KIND_SNAP_CISCO;
                        else
                            r.kind = KIND_SNAP_OTHER;
                        r.next_protocol = word_at(o + 3);
                        r.header_length = 5'(o + SNAP_LEN);
                        r.dest_sap      = d;
                        r.source_sap    = s;
                    end
                end else begin
                    r.kind          = KIND_LLC;
                    r.header_length = 5'(base + LLC_LEN);
                    r.dest_sap      = d;
                    r.source_sap    = s;
                end
            end
            headers_due.push_back(r);
        endfunction

        function void check_header(logic [2:0] kind, logic vlan_bit, logic [15:0] np,
                                   logic [4:0] hl, logic [7:0] ds, logic [7:0] ss);
            result_t e;
            if (headers_due.size() == 0) begin
                $error("result with no frame pending: frame_kind %0d", kind);
                errors++;
                return;
            end
            e = headers_due.pop_front();
            if (kind !== e.kind) begin
                $error("frame_kind: expected %0d, actual %0d", e.kind, kind);
                errors++;
            end
            if (vlan_bit !== e.vlan_tagged) begin
                $error("vlan_tagged: expected %0d, actual %0d", e.vlan_tagged, vlan_bit);
                errors++;
            end
            if (np !== e.next_protocol) begin
                $error("next_protocol: expected %h, actual %h", e.next_protocol, np);
                errors++;
            end
            if (hl !== e.header_length) begin
                $error("header_length: expected %0d, actual %0d", e.header_length, hl);
                errors++;
            end
            if (ds !== e.dest_sap) begin
                $error("dest_sap: expected %h, actual %h", e.dest_sap, ds);
                errors++;
            end
            if (ss !== e.source_sap) begin
                $error("source_sap: expected %h, actual %h", e.source_sap, ss);
                errors++;
            end
        endfunction

        function int pending();
            return headers_due.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    logic [7:0]             frame_byte;
    logic                   last_byte;
    logic                   empty;
    logic                   pop;
    logic [2:0]             frame_kind;
    logic                   vlan_tagged;
    logic [15:0]            next_protocol;
    logic [4:0]             header_length;
    logic [7:0]             dest_sap;
    logic [7:0]             source_sap;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    frame_header_checker sb;
    logic [7:0]          frame_buf[$];
    int unsigned         quiet_cycles = 0;
    int unsigned         stall_left = 0;
    bit                  pop_calm = 1'b0;

    ethernet_link_header_classifier_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .frame_byte    (frame_byte),
        .last_byte     (last_byte),
        .empty         (empty),
        .pop           (pop),
        .frame_kind    (frame_kind),
        .vlan_tagged   (vlan_tagged),
        .next_protocol (next_protocol),
        .header_length (header_length),
        .dest_sap      (dest_sap),
        .source_sap    (source_sap),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_write)
                sb.write_reg(cfg_index, cfg_data);
            if (push && !full)
                sb.take_byte(frame_byte, last_byte);
            if (pop && !empty)
                sb.check_header(frame_kind, vlan_tagged, next_protocol, header_length,
                                dest_sap, source_sap);
            if (cfg_write || (push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (stall_left != 0) begin
            pop        <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!pop_calm && $urandom_range(99, 0) < 25) begin
            pop        <= 1'b0;
            stall_left <= ($urandom_range(9, 0) == 0) ? $urandom_range(80, 15)
                                                      : $urandom_range(3, 0);
        end else
            pop <= 1'b1;
    end

    function automatic int gap_len();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [15:0] pick_high();
        int unsigned r;
        r = $urandom_range(19, 0);
        if (sb.limit == 16'hffff)
            return 16'($urandom);
        if (r == 0)
            return sb.limit + 16'd1;
        if (r == 1)
            return 16'hffff;
        return 16'($urandom_range(65535, 32'(sb.limit) + 1));
    endfunction

    function automatic logic [15:0] pick_len();
        int unsigned r;
        r = $urandom_range(19, 0);
        if (r == 0)
            return sb.limit;
        if (r == 1)
            return 16'd0;
        return 16'($urandom_range(32'(sb.limit), 0));
    endfunction

    task automatic idle_push(input int n);
        repeat (n) begin
            @(negedge clk);
            push       <= 1'b0;
            frame_byte <= 8'($urandom);
            last_byte  <= 1'($urandom);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        push       <= 1'b1;
        frame_byte <= b;
        last_byte  <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_frame();
        bit calm;
        calm = ($urandom_range(9, 0) < 3);
        foreach (frame_buf[i]) begin
            if (!calm)
                idle_push(gap_len());
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_one(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic set_regs(input logic [15:0] ll, input logic [15:0] vt,
                            input logic [23:0] oe, input logic [23:0] oa, input logic [23:0] oc);
        drain();
        write_one(REG_LENGTH_LIMIT, {8'($urandom), ll});
        write_one(REG_VLAN_TYPE, {8'($urandom), vt});
        write_one(REG_ORG_ETHER, oe);
        write_one(REG_ORG_APPLE, oa);
        write_one(REG_ORG_CISCO, oc);
        @(negedge clk);
        cfg_write <= 1'b0;
        cfg_data  <= 24'($urandom);
    endtask

    task automatic build_frame(input frame_shape_t shape, input logic [15:0] ftype,
                               input logic [23:0] org, input int extra, input int cut);
        int unsigned r;
        frame_buf.delete();
        if (shape == SHAPE_NOISE) begin
            repeat (extra + 1) frame_buf.push_back(8'($urandom));
        end else begin
            repeat (12) frame_buf.push_back(8'($urandom));
            if (shape == SHAPE_VLAN || shape == SHAPE_VLAN_LLC || shape == SHAPE_VLAN_SNAP) begin
                frame_buf.push_back(sb.vlan[15:8]);
                frame_buf.push_back(sb.vlan[7:0]);
                frame_buf.push_back(8'($urandom));
                frame_buf.push_back(8'($urandom));
            end
            frame_buf.push_back(ftype[15:8]);
            frame_buf.push_back(ftype[7:0]);
            if (shape == SHAPE_LLC || shape == SHAPE_VLAN_LLC) begin
                r = $urandom_range(9, 0);
                frame_buf.push_back(r < 2 ? SAP_SNAP : 8'($urandom));
                frame_buf.push_back(r < 2 ? SAP_SNAP : 8'($urandom));
                frame_buf.push_back(r == 0 ? CTRL_UI + 8'd1 : 8'($urandom));
            end
            if (shape == SHAPE_SNAP || shape == SHAPE_VLAN_SNAP) begin
                frame_buf.push_back(SAP_SNAP);
                frame_buf.push_back(SAP_SNAP);
                frame_buf.push_back(CTRL_UI);
                frame_buf.push_back(org[23:16]);
                frame_buf.push_back(org[15:8]);
                frame_buf.push_back(org[7:0]);
                frame_buf.push_back(8'($urandom));
                frame_buf.push_back(8'($urandom));
            end
            repeat (extra) frame_buf.push_back(8'($urandom));
        end
        while (cut > 0 && frame_buf.size() > cut)
            void'(frame_buf.pop_back());
    endtask

    task automatic random_frame();
        int unsigned  r;
        frame_shape_t shape;
        logic [15:0]  ftype;
        logic [23:0]  org;
        int           extra;
        int           cut;
        r = $urandom_range(99, 0);
        shape = r < 20 ? SHAPE_ETH : r < 35 ? SHAPE_VLAN : r < 47 ? SHAPE_LLC :
                r < 67 ? SHAPE_SNAP : r < 75 ? SHAPE_VLAN_LLC :
                r < 87 ? SHAPE_VLAN_SNAP : SHAPE_NOISE;
        if (shape == SHAPE_ETH || shape == SHAPE_VLAN)
            ftype = ($urandom_range(9, 0) == 0) ? sb.vlan : pick_high();
        else
            ftype = pick_len();
        case ($urandom_range(3, 0))
            0:       org = sb.org_ether;
            1:       org = sb.org_apple;
            2:       org = sb.org_cisco;
            default: org = 24'($urandom);
        endcase
        r = $urandom_range(99, 0);
        extra = r < 70 ? $urandom_range(3, 0) : r < 95 ? $urandom_range(10, 4)
                                                      : $urandom_range(30, 11);
        cut = ($urandom_range(3, 0) == 0) ? $urandom_range(26, 1) : 0;
        build_frame(shape, ftype, org, extra, cut);
        send_frame();
    endtask

    initial
    begin
        int phase_bytes;
        int phase_frames;
        sb         = new();
        rst_n      = 1'b0;
        push       <= 1'b0;
        frame_byte <= '0;
        last_byte  <= 1'b0;
        cfg_write  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        build_frame(SHAPE_ETH, 16'h0800, '0, 4, 0);
        send_frame();
        build_frame(SHAPE_ETH, 16'h0800, '0, 0, 13);
        send_frame();
        build_frame(SHAPE_ETH, LENGTH_LIMIT_RST + 16'd1, '0, 0, 0);
        send_frame();
        build_frame(SHAPE_LLC, LENGTH_LIMIT_RST, '0, 2, 0);
        send_frame();
        build_frame(SHAPE_LLC, 16'd0, '0, 0, 16);
        send_frame();
        build_frame(SHAPE_SNAP, 16'd46, ORG_ETHER_RST, 1, 0);
        send_frame();
        build_frame(SHAPE_SNAP, 16'd46, ORG_APPLE_RST, 0, 0);
        send_frame();
        build_frame(SHAPE_SNAP, 16'd46, ORG_CISCO_RST, 0, 0);
        send_frame();
        build_frame(SHAPE_SNAP, 16'd46, 24'h123456, 0, 0);
        send_frame();
        build_frame(SHAPE_SNAP, 16'd46, ORG_ETHER_RST, 0, 21);
        send_frame();
        build_frame(SHAPE_VLAN, 16'h86dd, '0, 3, 0);
        send_frame();
        build_frame(SHAPE_VLAN, 16'h0800, '0, 0, 17);
        send_frame();
        build_frame(SHAPE_VLAN, VLAN_TYPE_RST, '0, 0, 0);
        send_frame();
        build_frame(SHAPE_VLAN_LLC, 16'd100, '0, 0, 0);
        send_frame();
        build_frame(SHAPE_VLAN_SNAP, 16'd60, ORG_APPLE_RST, 0, 0);
        send_frame();
        build_frame(SHAPE_ETH, 16'hffff, '0, 30, 0);
        send_frame();
        build_frame(SHAPE_NOISE, '0, '0, 0, 0);
        send_frame();
        frame_buf.delete();
        repeat (20) frame_buf.push_back(8'hff);
        send_frame();
        frame_buf.delete();
        repeat (14) frame_buf.push_back(8'h00);
        send_frame();

        for (int p = 0; p < 6; p++) begin
            case (p)
                1: set_regs(16'd0, 16'hffff, 24'h0, 24'h0, 24'h0);
                2: set_regs(16'hffff, 16'h0000, 24'($urandom), 24'($urandom), 24'($urandom));
                3: begin
                    logic [23:0] shared;
                    shared = 24'($urandom);
                    set_regs(16'($urandom), 16'($urandom), 24'($urandom), shared, shared);
                end
                4: set_regs(LENGTH_LIMIT_RST, VLAN_TYPE_RST, 24'hffffff, ORG_APPLE_RST,
                            ORG_CISCO_RST);
                5: set_regs(16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom),
                            24'($urandom));
                default: ;
            endcase
            pop_calm     <= (p == 4);
            phase_bytes  = 0;
            phase_frames = 0;
            while (phase_bytes < 18 || phase_frames < 1) begin
                random_frame();
                phase_bytes  += frame_buf.size();
                phase_frames++;
            end
        end

        drain();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### ethernet_link_header_classifier_unit.f
hw/rtl/elhc_pkg.sv
hw/rtl/elhc_front.sv
hw/rtl/elhc_queue.sv
hw/rtl/elhc_back.sv
hw/rtl/ethernet_link_header_classifier_unit.sv
dv/tb.sv
